// ===== hw/rtl/blzu_pkg.sv =====
// Package for the backward LZ bitstream unpacker: payload structs, codes, phases.
// No dependencies.
`timescale 1ns / 1ps
package blzu_pkg;

	localparam int WINDOW_DEPTH_DEF = 4096;
	// length counters are sized for this limit, so it is fixed here
	localparam int MAX_OUTPUT_BYTES = 1048576;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_SUPPLY = 2'd1,
		OP_PULL = 2'd2,
		OP_BAD = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_BYTE = 3'd0,
		ST_NEED = 3'd1,
		ST_TAKEN = 3'd2,
		ST_DONE = 3'd3,
		ST_CHECK_BAD = 3'd4,
		ST_ERROR = 3'd5,
		ST_UNEXPECTED = 3'd6
	} status_t;

	typedef enum logic [3:0] {
		PH_IDLE, PH_HEAD, PH_TOKEN, PH_SHORT, PH_CODE, PH_RUN, PH_DONE, PH_ERR,
		PH_READ, PH_EMIT
	} phase_t;

	typedef enum logic [2:0] {
		PU_SELECT, PU_LIT_SHORT, PU_LIT_LONG, PU_DIST_TWO, PU_COPY_LEN, PU_DIST,
		PU_LIT_BYTE
	} purpose_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [31:0] word;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] byte_value;
		logic [19:0] byte_position;
		logic last;
	} out_item_t;

endpackage

// ===== hw/rtl/backward_lz_bitstream_unpacker_top.sv =====
// Backward LZ bitstream unpacker, top level and only module.
// Depends on blzu_pkg.
`timescale 1ns / 1ps

// Decodes a backward LZ stream (bytekiller scheme). Each transaction on the
// input gives exactly one result. A result that needs no decoding is offered
// the cycle after its input is accepted. A decoding pull runs a sequencer that
// takes one reservoir bit per cycle while it reads token or code bits, through
// a single shift-and-accumulate unit, and stops with a request for a word when
// the reservoir runs dry; it steps through each token or code bit, each
// finished code, entering a run, the registered window read of a copied byte
// and emitting the byte, in that order.
// The input is stalled while a transaction is in work or its result waits.
// The window comes up unwritten; no clearing pass is needed.
module backward_lz_bitstream_unpacker_top
	import blzu_pkg::*;
#(
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output out_item_t out_data
);
	localparam int AW = $clog2(WINDOW_DEPTH);

	logic [7:0] win_mem [WINDOW_DEPTH];
	logic [7:0] rd_q;

	phase_t phase_q, phase_d;
	purpose_t purp_q, purp_d;
	logic busy_q, busy_d;
	logic ov_q, ov_d;
	out_item_t res_q, res_d;
	logic [31:0] resv_q, resv_d, chk_q, chk_d;
	logic [20:0] rem_q, rem_d, tot_q, tot_d;
	logic [19:0] wpos_q, wpos_d;
	logic [8:0] crem_q, crem_d;
	logic [11:0] dist_q, dist_d, acc_q, acc_d;
	logic [3:0] cbits_q, cbits_d;
	logic lit_q, lit_d, fresh_q, fresh_d, want_q, want_d;
	logic [1:0] hdr_q, hdr_d;
	logic wr_en;
	logic [7:0] wr_val;
	logic bit_ok, bit_v;
	logic [31:0] resv_nx;
	logic [20:0] cnt;

	assign in_stall = busy_q || ov_q;
	assign out_valid = ov_q;
	assign out_data = res_q;

	// shared bit unit
	always_comb begin
		bit_ok = fresh_q || (resv_q > 32'd1);
		bit_v = resv_q[0];
		resv_nx = fresh_q ? {1'b1, resv_q[31:1]} : {1'b0, resv_q[31:1]};
	end

	always_comb begin
		phase_d = phase_q; purp_d = purp_q; busy_d = busy_q; ov_d = ov_q;
		res_d = res_q; resv_d = resv_q; chk_d = chk_q; rem_d = rem_q;
		tot_d = tot_q; wpos_d = wpos_q; crem_d = crem_q; dist_d = dist_q;
		acc_d = acc_q; cbits_d = cbits_q; lit_d = lit_q; fresh_d = fresh_q;
		want_d = want_q; hdr_d = hdr_q; wr_en = 1'b0; wr_val = '0; cnt = '0;
		if (ov_q && !out_stall) ov_d = 1'b0;
		if (in_valid && !in_stall) begin
			res_d = '0;
			unique case (op_t'(in_data.operation))
				OP_START: begin
					ov_d = 1'b1;
					resv_d = '0; chk_d = '0; crem_d = '0; dist_d = '0; lit_d = 1'b0;
					acc_d = '0; cbits_d = '0; purp_d = PU_SELECT; fresh_d = 1'b0;
					want_d = 1'b0; hdr_d = '0; rem_d = '0; tot_d = '0; wpos_d = '0;
					if (in_data.word == 32'd0 ||
						in_data.word > 32'(MAX_OUTPUT_BYTES)) begin
						phase_d = PH_ERR; res_d.status = ST_ERROR;
					end else begin
						tot_d = in_data.word[20:0]; rem_d = in_data.word[20:0];
						wpos_d = 20'(in_data.word - 32'd1);
						phase_d = PH_HEAD; res_d.status = ST_NEED;
					end
				end
				OP_SUPPLY: begin
					ov_d = 1'b1;
					if (phase_q == PH_HEAD) begin
						res_d.status = ST_TAKEN;
						if (hdr_q == 2'd0) begin
							chk_d = in_data.word; hdr_d = 2'd1;
						end else begin
							resv_d = in_data.word; chk_d = chk_q ^ in_data.word;
							hdr_d = 2'd2; phase_d = PH_TOKEN;
						end
					end else if (phase_q == PH_ERR) begin
						res_d.status = ST_ERROR;
					end else if (want_q && (phase_q == PH_TOKEN || phase_q == PH_SHORT ||
						phase_q == PH_CODE || phase_q == PH_RUN)) begin
						chk_d = chk_q ^ in_data.word; resv_d = in_data.word;
						fresh_d = 1'b1; want_d = 1'b0; res_d.status = ST_TAKEN;
					end else begin
						res_d.status = ST_UNEXPECTED;
					end
				end
				OP_PULL: begin
					if (phase_q == PH_IDLE || phase_q == PH_HEAD) begin
						ov_d = 1'b1; res_d.status = ST_UNEXPECTED;
					end else if (phase_q == PH_DONE) begin
						ov_d = 1'b1;
						res_d.status = (chk_q == 32'd0) ? ST_DONE : ST_CHECK_BAD;
					end else if (phase_q == PH_ERR) begin
						ov_d = 1'b1; res_d.status = ST_ERROR;
					end else if (want_q) begin
						ov_d = 1'b1; res_d.status = ST_NEED;
					end else begin
						busy_d = 1'b1;
					end
				end
				default: begin
					ov_d = 1'b1; res_d.status = ST_UNEXPECTED;
				end
			endcase
		end else if (busy_q) begin
			unique case (phase_q)
				PH_TOKEN, PH_SHORT: begin
					if (!bit_ok) begin
						want_d = 1'b1; busy_d = 1'b0; ov_d = 1'b1; res_d.status = ST_NEED;
					end else begin
						resv_d = resv_nx; fresh_d = 1'b0; acc_d = '0; phase_d = PH_CODE;
						if (phase_q == PH_TOKEN) begin
							if (!bit_v) phase_d = PH_SHORT;
							else begin cbits_d = 4'd2; purp_d = PU_SELECT; end
						end else if (!bit_v) begin
							cbits_d = 4'd3; purp_d = PU_LIT_SHORT;
						end else begin
							cbits_d = 4'd8; purp_d = PU_DIST_TWO;
						end
					end
				end
				PH_CODE: begin
					if (cbits_q != 4'd0) begin
						if (!bit_ok) begin
							want_d = 1'b1; busy_d = 1'b0; ov_d = 1'b1;
							res_d.status = ST_NEED;
						end else begin
							resv_d = resv_nx; fresh_d = 1'b0;
							acc_d = {acc_q[10:0], bit_v}; cbits_d = cbits_q - 4'd1;
						end
					end else begin
						acc_d = '0;
						// default for start-run purposes
						lit_d = 1'b1; cnt = 21'(acc_q) + 21'd1;
						unique case (purp_q)
							PU_SELECT: begin
								if (acc_q == 12'd3) begin
									cbits_d = 4'd8; purp_d = PU_LIT_LONG;
								end else if (acc_q < 12'd2) begin
									crem_d = 9'(acc_q + 12'd3);
									cbits_d = 4'(acc_q + 12'd9); purp_d = PU_DIST;
								end else begin
									cbits_d = 4'd8; purp_d = PU_COPY_LEN;
								end
							end
							PU_COPY_LEN: begin
								crem_d = 9'(acc_q + 12'd1); cbits_d = 4'd12; purp_d = PU_DIST;
							end
							PU_LIT_BYTE: begin
								// byte stays in the accumulator until it is emitted
								acc_d = acc_q;
								wr_en = 1'b1; wr_val = acc_q[7:0];
								phase_d = PH_EMIT;
							end
							PU_LIT_SHORT, PU_LIT_LONG, PU_DIST_TWO, PU_DIST: begin
								if (purp_q == PU_LIT_LONG) cnt = 21'(acc_q) + 21'd9;
								if (purp_q == PU_DIST_TWO || purp_q == PU_DIST) begin
									lit_d = 1'b0; dist_d = acc_q;
									cnt = (purp_q == PU_DIST) ? 21'(crem_q) : 21'd2;
								end
								phase_d = PH_RUN; crem_d = cnt[8:0];
								if (cnt > rem_q) begin
									phase_d = PH_ERR; lit_d = lit_q; crem_d = crem_q;
								end else if (!lit_d && (acc_q == 12'd0 ||
									21'(acc_q) > tot_q - rem_q)) begin
									phase_d = PH_ERR; lit_d = lit_q; crem_d = crem_q;
								end
								if (phase_d == PH_ERR) begin
									busy_d = 1'b0; ov_d = 1'b1; res_d.status = ST_ERROR;
								end
							end
							default: ;
						endcase
					end
				end
				PH_RUN: begin
					if (lit_q) begin
						acc_d = '0; cbits_d = 4'd8; purp_d = PU_LIT_BYTE; phase_d = PH_CODE;
					end else begin
						phase_d = PH_READ;
					end
				end
				PH_READ: begin
					wr_en = 1'b1; wr_val = rd_q; acc_d = {4'd0, rd_q}; phase_d = PH_EMIT;
				end
				PH_EMIT: begin
					busy_d = 1'b0; ov_d = 1'b1;
					res_d.status = ST_BYTE; res_d.byte_value = acc_q[7:0];
					res_d.byte_position = wpos_q; res_d.last = (wpos_q == 20'd0);
					rem_d = rem_q - 21'd1; crem_d = crem_q - 9'd1;
					wpos_d = (rem_q > 21'd1) ? 20'(rem_q - 21'd2) : 20'd0;
					if (rem_q == 21'd1) phase_d = PH_DONE;
					else if (crem_q == 9'd1) phase_d = PH_TOKEN;
					else phase_d = PH_RUN;
				end
				default: begin
					busy_d = 1'b0; ov_d = 1'b1; res_d.status = ST_ERROR; phase_d = PH_ERR;
				end
			endcase
		end
	end

	// history window: registered read, one write port
	always_ff @(posedge clk) begin
		rd_q <= win_mem[AW'(wpos_q + 20'(dist_q))];
		if (wr_en) win_mem[AW'(wpos_q)] <= wr_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; busy_q <= 1'b0; ov_q <= 1'b0; want_q <= 1'b0;
			fresh_q <= 1'b0; hdr_q <= '0; purp_q <= PU_SELECT; cbits_q <= '0;
			rem_q <= '0; tot_q <= '0; wpos_q <= '0; crem_q <= '0; dist_q <= '0;
			lit_q <= 1'b0; resv_q <= '0; chk_q <= '0; acc_q <= '0;
			res_q <= '0;
		end else begin
			phase_q <= phase_d; busy_q <= busy_d; ov_q <= ov_d; want_q <= want_d;
			fresh_q <= fresh_d; hdr_q <= hdr_d; purp_q <= purp_d; cbits_q <= cbits_d;
			rem_q <= rem_d; tot_q <= tot_d; wpos_q <= wpos_d; crem_q <= crem_d;
			dist_q <= dist_d; lit_q <= lit_d; resv_q <= resv_d; chk_q <= chk_d;
			acc_q <= acc_d; res_q <= res_d;
		end
	end

`ifndef SYNTHESIS
	a_busy_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy_q && ov_q)) else $error("busy with result pending");
	a_byte_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status == ST_BYTE) |-> 21'(out_data.byte_position) < tot_q)
		else $error("byte position out of range");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(out_data)) else $error("result changed");
`endif

endmodule

// ===== tb/sv/tb_backward_lz_bitstream_unpacker_top.sv =====
// Testbench for the backward LZ bitstream unpacker: encodes streams, drives them
// through the valid/stall channels and checks every result against a predictor.
// Depends on blzu_pkg and backward_lz_bitstream_unpacker_top.
`timescale 1ns / 1ps

import blzu_pkg::*;

class unpack_scoreboard;
	out_item_t want_q[$];
	int errors;

	// decoder state
	logic [31:0] res, chk;
	int unsigned remaining, wpos, total, cnt, cp_dist, bitsleft;
	logic [7:0] win [4096];
	bit litflag, fresh, wanted;
	logic [11:0] acc;
	phase_t ph;
	purpose_t purpose;
	int hdr;

	function new();
		errors = 0;
		clear();
	endfunction

	function void clear();
		res = 0; chk = 0; remaining = 0; wpos = 0; total = 0; cnt = 0; cp_dist = 0;
		bitsleft = 0; litflag = 0; fresh = 0; wanted = 0; acc = 0; hdr = 0;
		ph = PH_IDLE; purpose = PU_SELECT;
		foreach (win[i]) win[i] = 0;
	endfunction

	function out_item_t mk(status_t s, logic [7:0] v = 0, logic [19:0] p = 0, bit l = 0);
		out_item_t o;
		o.status = s; o.byte_value = v; o.byte_position = p; o.last = l;
		return o;
	endfunction

	function int take_bit();
		int b;
		if (fresh) begin
			b = res[0];
			res = {1'b1, res[31:1]};
			fresh = 0;
			return b;
		end
		if (res <= 1) begin
			wanted = 1;
			return 2;
		end
		b = res[0];
		res = res >> 1;
		return b;
	endfunction

	function void begin_code(int unsigned bits, purpose_t p);
		acc = 0; bitsleft = bits; purpose = p; ph = PH_CODE;
	endfunction

	function void start_run(bit lit, int unsigned count);
		if (count > remaining) ph = PH_ERR;
		else if (!lit && (cp_dist == 0 || cp_dist > total - remaining)) ph = PH_ERR;
		else begin
			litflag = lit; cnt = count; ph = PH_RUN;
		end
	endfunction

	function out_item_t emit(logic [7:0] v);
		out_item_t o;
		win[wpos % 4096] = v;
		o = mk(ST_BYTE, v, wpos[19:0], wpos == 0);
		remaining--;
		cnt--;
		wpos = remaining ? remaining - 1 : 0;
		if (remaining == 0) ph = PH_DONE;
		else if (cnt == 0) ph = PH_TOKEN;
		else ph = PH_RUN;
		return o;
	endfunction

	function out_item_t decode_pull();
		int b;
		while (1) begin
			case (ph)
				PH_TOKEN: begin
					b = take_bit();
					if (b == 2) return mk(ST_NEED);
					if (b == 0) ph = PH_SHORT;
					else begin_code(2, PU_SELECT);
				end
				PH_SHORT: begin
					b = take_bit();
					if (b == 2) return mk(ST_NEED);
					if (b == 0) begin_code(3, PU_LIT_SHORT);
					else begin_code(8, PU_DIST_TWO);
				end
				PH_CODE: begin
					while (bitsleft) begin
						b = take_bit();
						if (b == 2) return mk(ST_NEED);
						acc = {acc[10:0], b[0]};
						bitsleft--;
					end
					case (purpose)
						PU_SELECT: begin
							if (acc == 3) begin_code(8, PU_LIT_LONG);
							else if (acc < 2) begin
								cnt = acc + 3;
								begin_code(acc + 9, PU_DIST);
							end else begin_code(8, PU_COPY_LEN);
						end
						PU_LIT_SHORT: start_run(1, acc + 1);
						PU_LIT_LONG: start_run(1, acc + 9);
						PU_DIST_TWO: begin
							cp_dist = acc;
							start_run(0, 2);
						end
						PU_COPY_LEN: begin
							cnt = acc + 1;
							begin_code(12, PU_DIST);
						end
						PU_DIST: begin
							cp_dist = acc;
							start_run(0, cnt);
						end
						default: return emit(acc[7:0]);
					endcase
				end
				PH_RUN: begin
					if (litflag) begin_code(8, PU_LIT_BYTE);
					else return emit(win[(wpos + cp_dist) % 4096]);
				end
				default: begin
					ph = PH_ERR;
					return mk(ST_ERROR);
				end
			endcase
		end
		return mk(ST_ERROR);
	endfunction

	// note an accepted input transaction; returns the predicted status
	function status_t note(in_item_t it);
		out_item_t o;
		logic [31:0] w;
		w = it.word;
		case (op_t'(it.operation))
			OP_START: begin
				clear();
				if (w == 0 || w > 32'd1048576) begin
					ph = PH_ERR;
					o = mk(ST_ERROR);
				end else begin
					total = w; remaining = w; wpos = w - 1; ph = PH_HEAD;
					o = mk(ST_NEED);
				end
			end
			OP_SUPPLY: begin
				if (ph == PH_HEAD) begin
					if (hdr == 0) begin
						chk = w; hdr = 1;
					end else begin
						res = w; chk ^= w; hdr = 2; ph = PH_TOKEN;
					end
					o = mk(ST_TAKEN);
				end else if (ph == PH_ERR) o = mk(ST_ERROR);
				else if (wanted && ph inside {PH_TOKEN, PH_SHORT, PH_CODE, PH_RUN}) begin
					chk ^= w; res = w; fresh = 1; wanted = 0;
					o = mk(ST_TAKEN);
				end else o = mk(ST_UNEXPECTED);
			end
			OP_PULL: begin
				if (ph == PH_IDLE || ph == PH_HEAD) o = mk(ST_UNEXPECTED);
				else if (ph == PH_DONE) o = mk(chk == 0 ? ST_DONE : ST_CHECK_BAD);
				else if (ph == PH_ERR) o = mk(ST_ERROR);
				else if (wanted) o = mk(ST_NEED);
				else o = decode_pull();
			end
			default: o = mk(ST_UNEXPECTED);
		endcase
		want_q.push_back(o);
		return status_t'(o.status);
	endfunction

	function void check(out_item_t got);
		out_item_t w;
		if (want_q.size() == 0) begin
			$error("result with nothing expected: status %0d", got.status);
			errors++;
			return;
		end
		w = want_q.pop_front();
		if (got.status !== w.status) begin
			$error("status: expected %0d actual %0d", w.status, got.status);
			errors++;
		end
		if (got.byte_value !== w.byte_value) begin
			$error("byte_value: expected %0h actual %0h", w.byte_value, got.byte_value);
			errors++;
		end
		if (got.byte_position !== w.byte_position) begin
			$error("byte_position: expected %0d actual %0d", w.byte_position,
				got.byte_position);
			errors++;
		end
		if (got.last !== w.last) begin
			$error("last: expected %0d actual %0d", w.last, got.last);
			errors++;
		end
	endfunction
endclass

module tb_backward_lz_bitstream_unpacker_top;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid, out_stall;
	in_item_t in_data;
	logic in_stall, out_valid;
	out_item_t out_data;

	unpack_scoreboard sb = new();
	int n_sent = 0;
	int idle_cycles = 0;
	bit hold_done = 0;

	always #6 clk = ~clk;

	backward_lz_bitstream_unpacker_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// stretches of items with no idling at all
	function automatic bit quiet();
		return ((n_sent / 150) % 4) == 2;
	endfunction

	function automatic int pick_gap();
		if (quiet()) return 0;
		if ($urandom_range(0, 99) < 60) return 0;
		if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send(op_t op, logic [31:0] w, output status_t st);
		int gap;
		in_item_t it;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		it.operation = op;
		it.word = w;
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		st = sb.note(it);
		n_sent++;
	endtask

	// bit stream under construction, first bit taken first
	bit stream_bits[$];

	task automatic push_code(int unsigned v, int n);
		for (int i = n - 1; i >= 0; i--) stream_bits.push_back(v[i]);
	endtask

	// encode a random token stream for len bytes into packed words
	task automatic encode(int unsigned len, output logic [31:0] words[$]);
		int unsigned rem, written, n, d, k, choice;
		logic [31:0] w;
		stream_bits.delete();
		words.delete();
		rem = len;
		written = 0;
		while (rem > 0) begin
			choice = (written == 0) ? 0 : $urandom_range(0, 5);
			if (choice == 1 && rem >= 2) begin
				d = $urandom_range(1, written < 255 ? written : 255);
				push_code(1, 2);
				push_code(d, 8);
				n = 2;
			end else if (choice == 2 && rem >= 3) begin
				d = $urandom_range(1, written < 511 ? written : 511);
				push_code(4, 3);
				push_code(d, 9);
				n = 3;
			end else if (choice == 3 && rem >= 4) begin
				d = $urandom_range(1, written < 1023 ? written : 1023);
				push_code(5, 3);
				push_code(d, 10);
				n = 4;
			end else if (choice == 4) begin
				n = $urandom_range(1, rem < 256 ? rem : 256);
				d = $urandom_range(1, written < 4095 ? written : 4095);
				push_code(6, 3);
				push_code(n - 1, 8);
				push_code(d, 12);
			end else if (rem >= 9 && $urandom_range(0, 2) == 0) begin
				n = $urandom_range(9, rem < 264 ? rem : 264);
				push_code(7, 3);
				push_code(n - 9, 8);
				for (int i = 0; i < n; i++) push_code($urandom_range(0, 255), 8);
			end else begin
				n = $urandom_range(1, rem < 8 ? rem : 8);
				push_code(0, 2);
				push_code(n - 1, 3);
				for (int i = 0; i < n; i++) push_code($urandom_range(0, 255), 8);
			end
			rem -= n;
			written += n;
		end
		// first bit word: marker above the used bits
		k = $urandom_range(1, 31);
		if (k > stream_bits.size()) k = stream_bits.size();
		w = 32'd1 << k;
		for (int i = 0; i < k; i++) w[i] = stream_bits.pop_front();
		words.push_back(w);
		while (stream_bits.size() > 0) begin
			w = $urandom;
			for (int i = 0; i < 32 && stream_bits.size() > 0; i++)
				w[i] = stream_bits.pop_front();
			words.push_back(w);
		end
	endtask

	// one resource: start, header, then pulls answering word requests
	task automatic run_stream(int unsigned len, bit corrupt, bit noisy, bit garbage);
		logic [31:0] words[$];
		logic [31:0] check_w;
		status_t st;
		int guard;
		if (garbage) begin
			words.delete();
			for (int i = 0; i < 40; i++) words.push_back($urandom);
		end else encode(len, words);
		check_w = 0;
		foreach (words[i]) check_w ^= words[i];
		if (corrupt) check_w ^= 32'd1 << $urandom_range(0, 31);
		send(OP_START, len, st);
		send(OP_SUPPLY, check_w, st);
		send(OP_SUPPLY, words.pop_front(), st);
		guard = 4 * len + 60;
		while (guard > 0) begin
			guard--;
			if (noisy && $urandom_range(0, 30) == 0)
				send(op_t'($urandom_range(1, 3)), $urandom, st);
			send(OP_PULL, $urandom, st);
			if (st == ST_NEED) begin
				if (noisy && $urandom_range(0, 3) == 0) send(OP_PULL, $urandom, st);
				send(OP_SUPPLY, words.size() ? words.pop_front() : $urandom, st);
			end else if (st != ST_BYTE) begin
				if ($urandom_range(0, 1)) send(OP_PULL, $urandom, st);
				break;
			end
		end
	endtask

	// receiver: random stalls, and one long hold-off
	initial begin
		int burst;
		burst = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) sb.check(out_data);
			if (!hold_done && n_sent >= 700) begin
				hold_done = 1;
				burst = HOLD_CYCLES;
			end
			if (burst == 0 && !quiet() && $urandom_range(0, 7) == 0) burst = pick_gap();
			if (burst > 0) begin
				out_stall <= 1'b1;
				burst--;
			end else out_stall <= 1'b0;
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		status_t st;
		in_item_t zero_item;
		zero_item = '0;
		in_valid <= 1'b0;
		in_data <= zero_item;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: unexpected and bad items, length extremes, error phase
		send(OP_BAD, 32'hFFFF_FFFF, st);
		send(OP_SUPPLY, 32'h0, st);
		send(OP_PULL, 32'h0, st);
		send(OP_START, 32'd0, st);
		send(OP_SUPPLY, 32'h1234_5678, st);
		send(OP_PULL, 32'h0, st);
		send(OP_START, 32'hFFFF_FFFF, st);
		send(OP_START, 32'd1048577, st);
		send(OP_START, 32'd1048576, st);
		send(OP_PULL, 32'h0, st);
		send(OP_SUPPLY, 32'hFFFF_FFFF, st);
		send(OP_PULL, 32'h0, st);
		send(OP_SUPPLY, 32'h0, st);
		send(OP_PULL, 32'h0, st);
		send(OP_PULL, 32'h0, st);
		send(OP_BAD, 32'h0, st);
		run_stream(1, 0, 0, 0);
		run_stream(3, 1, 0, 0);

		// random: mostly well-formed streams, some broken or noisy
		while (n_sent < 1850) begin
			case ($urandom_range(0, 9))
				0: run_stream($urandom_range(1, 50), 0, 0, 1);
				1: run_stream($urandom_range(1, 60), 0, 1, 0);
				2: run_stream($urandom_range(1, 60), 1, 0, 0);
				3: run_stream($urandom_range(100, 400), 0, 0, 0);
				4: send(op_t'($urandom_range(0, 3)), $urandom_range(0, 3) == 0 ?
					$urandom : $urandom_range(0, 20), st);
				default: run_stream($urandom_range(1, 60), 0, 0, 0);
			endcase
		end
		in_valid <= 1'b0;

		while (sb.want_q.size() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.errors == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end
endmodule
